### rtl/lmrg_pkg.sv
package lmrg_pkg;

	// Generator constants
	localparam logic [31:0] LCG_MUL   = 32'd1103515245;
	localparam logic [63:0] LCG_INC   = 64'd12345;
	localparam logic [15:0] MWC_ZMUL  = 16'd36969;
	localparam logic [15:0] MWC_WMUL  = 16'd18000;
	localparam logic [31:0] Z_BAD     = 32'h9068ffff;
	localparam logic [31:0] W_BAD     = 32'h464fffff;
	localparam logic [63:0] LCG_RESET = 64'd1;
	localparam logic [31:0] MWC_RESET = 32'd2;

	// Unsigned scaling divides by 2^32 - 1
	localparam logic [31:0] U32_ALL_ONES = 32'hFFFFFFFF;
	localparam logic [31:0] U32_ONES_M1  = 32'hFFFFFFFE;

	// Item queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_LCG_RAW   = 2'd0,
		OP_MWC_RAW   = 2'd1,
		OP_LCG_RANGE = 2'd2,
		OP_MWC_RANGE = 2'd3
	} lmrg_op_t;

	// Classified request as held in the queue
	typedef struct packed {
		lmrg_op_t           op;
		logic [31:0]        low;
		logic signed [32:0] diff;
		logic               inverted;
	} lmrg_item_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_LCG_LO,
		B_LCG_HI,
		B_LCG_SUM,
		B_LCG_RAW,
		B_MWC_STEP,
		B_MWC_RAW,
		B_SCALE_MUL,
		B_SGN_QUOT,
		B_UNS_SUM,
		B_UNS_QUOT,
		B_ADD_LOW,
		B_DONE
	} lmrg_state_t;

endpackage

### rtl/lmrg_ifs.sv
interface lmrg_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [31:0] low_bound;
	logic [31:0] high_bound;

	modport source (output valid, output opcode, output low_bound, output high_bound,
		input ready);
	modport sink (input valid, input opcode, input low_bound, input high_bound,
		output ready);
endinterface

interface lmrg_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [32:0] value;
	logic               range_error;

	modport source (output valid, output value, output range_error, input ready);
	modport sink (input valid, input value, input range_error, output ready);
endinterface

### rtl/lmrg_front.sv
module lmrg_front (
	input  logic                clk,
	input  logic                arst_n,
	lmrg_req_if.sink            req,
	input  logic                pop,
	output logic                head_valid,
	output lmrg_pkg::lmrg_item_t head
);

	lmrg_pkg::lmrg_item_t             mem_q [lmrg_pkg::QUEUE_DEPTH];
	logic [lmrg_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [lmrg_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [lmrg_pkg::QCNT_W-1:0]      count_q;
	lmrg_pkg::lmrg_item_t             item;
	lmrg_pkg::lmrg_op_t               op;
	logic                             sext;
	logic signed [32:0]               low_x;
	logic signed [32:0]               high_x;
	logic                             push;

	// Classify: bounds are signed for the LCG range, unsigned for the MWC range
	always_comb begin
		op            = lmrg_pkg::lmrg_op_t'(req.opcode);
		sext          = (op == lmrg_pkg::OP_LCG_RANGE);
		low_x         = {sext & req.low_bound[31], req.low_bound};
		high_x        = {sext & req.high_bound[31], req.high_bound};
		item.op       = op;
		item.low      = req.low_bound;
		item.diff     = high_x - low_x;
		item.inverted = (op == lmrg_pkg::OP_MWC_RANGE) && item.diff[32];
	end

	assign req.ready  = (count_q != lmrg_pkg::QCNT_W'(lmrg_pkg::QUEUE_DEPTH));
	assign push       = req.valid && req.ready;
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Store the classified item
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == lmrg_pkg::QPTR_W'(lmrg_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == lmrg_pkg::QPTR_W'(lmrg_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/lmrg_back.sv
module lmrg_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                seed_we,
	input  logic [31:0]         seed_wdata,
	input  logic                head_valid,
	input  lmrg_pkg::lmrg_item_t head,
	output logic                pop,
	lmrg_rsp_if.source          rsp
);

	lmrg_pkg::lmrg_state_t state_q;
	lmrg_pkg::lmrg_state_t state_d;
	lmrg_pkg::lmrg_item_t  item_q;

	logic [63:0]        lcg_q;
	logic [31:0]        z_q;
	logic [31:0]        w_q;
	logic [63:0]        prod_q;
	logic [31:0]        mul_hi_q;
	logic [31:0]        r_q;
	logic [32:0]        sum_q;
	logic signed [32:0] t_q;
	logic [32:0]        res_q;
	logic               out_valid_q;
	logic signed [32:0] out_value_q;
	logic               out_err_q;

	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] mul_p;
	logic [31:0]        seed_z;
	logic [31:0]        seed_w;
	logic [63:0]        lcg_next;
	logic [14:0]        lcg_raw;
	logic [31:0]        z_next;
	logic [31:0]        w_next;
	logic [31:0]        mwc_raw;
	logic               uns_extra;
	logic               low_ext;
	logic               out_load;

	// Share one multiplier across the LCG halves and the range scaling
	always_comb begin
		mul_a = {1'b0, lcg_q[31:0]};
		mul_b = {1'b0, lmrg_pkg::LCG_MUL};
		if (state_q == lmrg_pkg::B_LCG_HI) begin
			mul_a = {1'b0, lcg_q[63:32]};
		end else if (state_q == lmrg_pkg::B_SCALE_MUL) begin
			mul_a = item_q.diff;
			mul_b = {1'b0, r_q};
		end
	end
	assign mul_p = mul_a * mul_b;

	// Generator and scaling arithmetic
	always_comb begin
		seed_z    = seed_wdata;
		seed_w    = {1'b0, seed_wdata[31:1]};
		if (seed_z == '0 || seed_z == lmrg_pkg::Z_BAD) begin
			seed_z = seed_z + 32'd1;
		end
		if (seed_w == '0 || seed_w == lmrg_pkg::W_BAD) begin
			seed_w = seed_w + 32'd1;
		end
		lcg_next  = prod_q + {mul_hi_q, 32'd0} + lmrg_pkg::LCG_INC;
		// Truncate toward zero: bump the floor when negative with a remainder
		lcg_raw   = lcg_q[30:16] + 15'(lcg_q[63] && (lcg_q[15:0] != '0));
		z_next    = {16'd0, lmrg_pkg::MWC_ZMUL} * {16'd0, z_q[15:0]} + {16'd0, z_q[31:16]};
		w_next    = {16'd0, lmrg_pkg::MWC_WMUL} * {16'd0, w_q[15:0]} + {16'd0, w_q[31:16]};
		mwc_raw   = {z_q[15:0], 16'd0} + w_q;
		uns_extra = sum_q[32] ? (sum_q[31:0] >= lmrg_pkg::U32_ONES_M1) :
			(sum_q[31:0] == lmrg_pkg::U32_ALL_ONES);
		low_ext   = (item_q.op == lmrg_pkg::OP_LCG_RANGE) && item_q.low[31];
	end

	// Sequence one item through the back end
	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			lmrg_pkg::B_IDLE: begin
				if (head_valid) begin
					pop     = 1'b1;
					state_d = head.op[0] ? lmrg_pkg::B_MWC_STEP : lmrg_pkg::B_LCG_LO;
				end
			end
			lmrg_pkg::B_LCG_LO:  state_d = lmrg_pkg::B_LCG_HI;
			lmrg_pkg::B_LCG_HI:  state_d = lmrg_pkg::B_LCG_SUM;
			lmrg_pkg::B_LCG_SUM: state_d = lmrg_pkg::B_LCG_RAW;
			lmrg_pkg::B_LCG_RAW: begin
				state_d = (item_q.op == lmrg_pkg::OP_LCG_RAW) ?
					lmrg_pkg::B_DONE : lmrg_pkg::B_SCALE_MUL;
			end
			lmrg_pkg::B_MWC_STEP: state_d = lmrg_pkg::B_MWC_RAW;
			lmrg_pkg::B_MWC_RAW: begin
				state_d = (item_q.op == lmrg_pkg::OP_MWC_RAW || item_q.inverted) ?
					lmrg_pkg::B_DONE : lmrg_pkg::B_SCALE_MUL;
			end
			lmrg_pkg::B_SCALE_MUL: begin
				state_d = (item_q.op == lmrg_pkg::OP_LCG_RANGE) ?
					lmrg_pkg::B_SGN_QUOT : lmrg_pkg::B_UNS_SUM;
			end
			lmrg_pkg::B_SGN_QUOT: state_d = lmrg_pkg::B_ADD_LOW;
			lmrg_pkg::B_UNS_SUM:  state_d = lmrg_pkg::B_UNS_QUOT;
			lmrg_pkg::B_UNS_QUOT: state_d = lmrg_pkg::B_ADD_LOW;
			lmrg_pkg::B_ADD_LOW:  state_d = lmrg_pkg::B_DONE;
			lmrg_pkg::B_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = lmrg_pkg::B_IDLE;
				end
			end
			default: state_d = lmrg_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lmrg_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Generator state: reload on seed write, advance in its step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_q <= lmrg_pkg::LCG_RESET;
			z_q   <= lmrg_pkg::MWC_RESET;
			w_q   <= lmrg_pkg::MWC_RESET;
		end else if (seed_we) begin
			lcg_q <= {32'd0, seed_wdata};
			z_q   <= seed_z;
			w_q   <= seed_w;
		end else begin
			if (state_q == lmrg_pkg::B_LCG_SUM) begin
				lcg_q <= lcg_next;
			end
			if (state_q == lmrg_pkg::B_MWC_STEP) begin
				z_q <= z_next;
				w_q <= w_next;
			end
		end
	end

	// Working registers of the current item
	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
		end
		unique case (state_q)
			lmrg_pkg::B_LCG_LO:    prod_q   <= mul_p[63:0];
			lmrg_pkg::B_LCG_HI:    mul_hi_q <= mul_p[31:0];
			lmrg_pkg::B_LCG_RAW: begin
				r_q   <= {17'd0, lcg_raw};
				res_q <= {18'd0, lcg_raw};
			end
			lmrg_pkg::B_MWC_RAW: begin
				r_q   <= mwc_raw;
				res_q <= item_q.inverted ? {1'b0, item_q.low} : {1'b0, mwc_raw};
			end
			lmrg_pkg::B_SCALE_MUL: prod_q   <= mul_p[63:0];
			lmrg_pkg::B_SGN_QUOT: begin
				t_q <= prod_q[47:15] + 33'(prod_q[63] && (prod_q[14:0] != '0));
			end
			lmrg_pkg::B_UNS_SUM:   sum_q <= {1'b0, prod_q[63:32]} + {1'b0, prod_q[31:0]};
			lmrg_pkg::B_UNS_QUOT: begin
				t_q <= {1'b0, prod_q[63:32]} + 33'(sum_q[32]) + 33'(uns_extra);
			end
			lmrg_pkg::B_ADD_LOW:   res_q <= {low_ext, item_q.low} + t_q;
			default: begin
			end
		endcase
	end

	// Output register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= res_q;
			out_err_q   <= (item_q.op == lmrg_pkg::OP_MWC_RANGE) && item_q.inverted;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.value       = out_value_q;
	assign rsp.range_error = out_err_q;

endmodule

### rtl/lcg_mwc_random_generator.sv
// Random number block with a 64-bit LCG and a dual 16-bit multiply-with-carry.
// Request channel (req): opcode picks the draw: raw LCG (15 bits), raw MWC
// (32 bits), LCG scaled into a signed [low_bound, high_bound] range, or MWC
// scaled into an unsigned range. One response per request on rsp: value
// (33-bit two's complement) and range_error, set for an inverted unsigned range
// (value is then low_bound).
// seed_we/seed_wdata reload both generators; write only while no request is
// outstanding.
// The back-end step sequencer, which owns the single shared 33x33 multiplier,
// works on one request at a time: it takes the next from the queue only after
// loading the last result into the response register. Raw draws and an
// inverted range skip the scaling steps.
// A two-entry queue after the front classifier keeps accepting requests while
// the back end works or its result waits.
// Reset: LCG state 1, MWC z and w both 2, queue empty, no response pending.
// A stalled receiver holds the response register; the back end then waits with
// its next result, and requests back up into the queue, then drop req.ready.
module lcg_mwc_random_generator (
	input  logic        clk,
	input  logic        arst_n,
	lmrg_req_if.sink    req,
	lmrg_rsp_if.source  rsp,
	input  logic        seed_we,
	input  logic [31:0] seed_wdata
);

	logic                 pop;
	logic                 head_valid;
	lmrg_pkg::lmrg_item_t head;

	lmrg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	lmrg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_we    (seed_we),
		.seed_wdata (seed_wdata),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule
